/* hw/rtl/b64e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-ASCII mapping of the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	// group phase codes
	localparam logic [1:0] PHASE_0 = 2'd0;
	localparam logic [1:0] PHASE_1 = 2'd1;
	localparam logic [1:0] PHASE_2 = 2'd2;

	// register indexes
	localparam logic REG_MODE = 1'b0;

	// ascii codes
	localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'
	localparam logic [7:0] CHAR_DASH  = 8'h2d;  // '-'
	localparam logic [7:0] CHAR_UNDER = 8'h5f;  // '_'
	localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
	localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
	localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

	// queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// one group of characters made by one byte
	typedef struct packed {
		logic [3:0][7:0] chars;   // chars[0] goes out first
		logic [1:0]      cnt_m1;  // number of characters minus one
		logic            last;    // group ends the message
	} grp_t;

	// queue status seen by the front, the back and the checks
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// sextet to alphabet character
	function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
		logic [7:0] v8;
		logic [7:0] c;
		v8 = {2'b00, v};
		if (v8 < 8'd26) begin
			c = CHAR_UC_A + v8;
		end else if (v8 < 8'd52) begin
			c = CHAR_LC_A + (v8 - 8'd26);
		end else if (v8 < 8'd62) begin
			c = CHAR_ZERO + (v8 - 8'd52);
		end else if (v8 == 8'd62) begin
			c = url ? CHAR_DASH : CHAR_PLUS;
		end else begin
			c = url ? CHAR_UNDER : CHAR_SLASH;
		end
		return c;
	endfunction

endpackage

/* hw/rtl/b64e_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group phase and carry bits, and builds the
// group of characters each byte produces.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              web_safe,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  b64e_pkg::q_stat_t q_stat,
	output logic              push,
	output b64e_pkg::grp_t    push_grp,
	output logic [1:0]        phase
);
	import b64e_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic       pad;

	assign byte_ready = !q_stat.full;
	assign push       = byte_valid && byte_ready;
	assign pad        = !web_safe;
	assign phase      = phase_q;

	// build the character group and the next state
	always_comb begin
		push_grp.chars  = {4{CHAR_PAD}};
		push_grp.cnt_m1 = 2'd0;
		push_grp.last   = last_byte;
		phase_d         = PHASE_0;
		carry_d         = 4'd0;
		unique case (phase_q)
			PHASE_1: begin
				push_grp.chars[0] = sextet_char({carry_q[1:0], data_byte[7:4]}, web_safe);
				if (last_byte) begin
					push_grp.chars[1] = sextet_char({data_byte[3:0], 2'b00}, web_safe);
					push_grp.cnt_m1   = pad ? 2'd2 : 2'd1;
				end else begin
					phase_d = PHASE_2;
					carry_d = data_byte[3:0];
				end
			end
			PHASE_2: begin
				push_grp.chars[0] = sextet_char({carry_q, data_byte[7:6]}, web_safe);
				push_grp.chars[1] = sextet_char(data_byte[5:0], web_safe);
				push_grp.cnt_m1   = 2'd1;
			end
			default: begin
				push_grp.chars[0] = sextet_char(data_byte[7:2], web_safe);
				if (last_byte) begin
					push_grp.chars[1] = sextet_char({data_byte[1:0], 4'b0000}, web_safe);
					push_grp.cnt_m1   = pad ? 2'd3 : 2'd1;
				end else begin
					phase_d = PHASE_1;
					carry_d = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	// phase and carry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_0;
			carry_q <= 4'd0;
		end else if (push) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

/* hw/rtl/b64e_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of character groups between front and back.
// ----------------------------------------------------------------------------
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::grp_t    push_grp,
	input  logic              pop,
	output b64e_pkg::grp_t    head_grp,
	output b64e_pkg::q_stat_t q_stat
);
	import b64e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	grp_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head_grp     = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CNT_FULL);
	assign q_stat.empty = (cnt_q == '0);

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/b64e_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head group one character per cycle, while the receiver takes them, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64e_pkg::grp_t    head_grp,
	input  b64e_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic [7:0]        out_char,
	output logic              last_char,
	output logic              char_valid,
	input  logic              char_ready
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load       = !q_stat.empty && (!valid_q || char_ready);
	assign at_end     = (idx_q == head_grp.cnt_m1);
	assign pop        = load && at_end;
	assign char_valid = valid_q;
	assign out_char   = char_q;
	assign last_char  = last_q;

	// character index within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (char_ready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head_grp.chars[idx_q];
			last_q <= at_end && head_grp.last;
		end
	end

endmodule

/* hw/rtl/base64_stream_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder: raw bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid/byte_ready) carries data_byte and last_byte;
//   last_byte marks the final byte of a message. Output channel
//   (char_valid/char_ready) carries out_char and last_char; last_char marks
//   the final character of the encoded message, padding included.
//   Register 0 (APB byte address 0), bit 0: url_safe_mode. 0 gives the
//   standard alphabet with '=' padding, 1 the URL-safe alphabet, no padding.
//   Write it only while no message is in flight.
//   The first character of a byte passes through the group queue and the
//   output register. The output register sends one character per cycle
//   while the receiver is ready; a final byte may produce up to 4 characters.
//   Bytes enter back to back while the two-group queue between the byte
//   front end and the character serializer has room.
//   When the receiver stalls, the output holds, the queue fills and
//   byte_ready drops. Reset clears the phase, the queue and the output valid,
//   and sets the standard alphabet.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte channel
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        byte_valid,
	output logic        byte_ready,
	// character channel
	output logic [7:0]  out_char,
	output logic        last_char,
	output logic        char_valid,
	input  logic        char_ready
);
	import b64e_pkg::*;

	logic    web_safe_q;
	logic    reg_wr;
	logic    push;
	logic    pop;
	grp_t    push_grp;
	grp_t    head_grp;
	q_stat_t q_stat;
	logic [1:0] phase;

	// register access
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
	assign prdata = (paddr[2] == REG_MODE) ? {31'd0, web_safe_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			web_safe_q <= 1'b0;
		end else if (reg_wr) begin
			web_safe_q <= pwdata[0];
		end
	end

	// byte front end
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.web_safe   (web_safe_q),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.q_stat     (q_stat),
		.push       (push),
		.push_grp   (push_grp),
		.phase      (phase)
	);

	// group queue
	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head_grp (head_grp),
		.q_stat   (q_stat)
	);

	// character serializer
	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_grp   (head_grp),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_char   (out_char),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

	// checks
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(push && last_byte) |=> (phase == PHASE_0))
		else $error("phase not cleared after final byte");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming Base64 encoder. A driver feeds raw
// bytes from a queue, a monitor predicts the character stream per accepted
// byte and compares every character transfer in order, field by field.
// Directed messages cover every group phase, both alphabets, padding and a
// mode change inside a message; random messages follow under three idling mixes.
// ----------------------------------------------------------------------------
module testbench;
	import b64e_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_MAX    = 10;

	// register byte addresses: index 0 is the mode, index 1 is unmapped
	localparam logic [2:0] ADDR_MODE     = {REG_MODE, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} enc_char_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  out_char;
	logic        last_char;
	logic        char_valid;
	logic        char_ready;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.out_char   (out_char),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

	string       b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	raw_byte_t   byte_queue[$];
	enc_char_t   expected_chars[$];
	logic        url_mode;
	logic [1:0]  enc_phase;
	logic [3:0]  enc_carry;
	logic        byte_taken;
	int          bytes_queued;
	int          bytes_accepted;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          errors;
	int          cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sextet to ascii under the current mode
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		c = b64_alphabet[v];
		if (url_mode && c == CHAR_PLUS) c = CHAR_DASH;
		else if (url_mode && c == CHAR_SLASH) c = CHAR_UNDER;
		return c;
	endfunction

	function automatic void add_char(input logic [7:0] code, input logic fin);
		expected_chars.push_back('{code: code, fin: fin});
	endfunction

	// characters produced by one accepted byte, plus the phase update
	function automatic void predict_chars(input logic [7:0] b, input logic fin);
		logic pad;
		pad = !url_mode;
		case (enc_phase)
			PHASE_1: begin
				add_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
				if (fin) begin
					add_char(b64_char({b[3:0], 2'b00}), !pad);
					if (pad) add_char(CHAR_PAD, 1'b1);
				end else begin
					enc_carry = b[3:0];
					enc_phase = PHASE_2;
				end
			end
			PHASE_2: begin
				add_char(b64_char({enc_carry, b[7:6]}), 1'b0);
				add_char(b64_char(b[5:0]), fin);
				enc_carry = 4'd0;
				enc_phase = PHASE_0;
			end
			default: begin
				add_char(b64_char(b[7:2]), 1'b0);
				if (fin) begin
					add_char(b64_char({b[1:0], 4'b0000}), !pad);
					if (pad) begin
						add_char(CHAR_PAD, 1'b0);
						add_char(CHAR_PAD, 1'b1);
					end
				end else begin
					enc_carry = {2'b00, b[1:0]};
					enc_phase = PHASE_1;
				end
			end
		endcase
		if (fin) begin
			enc_phase = PHASE_0;
			enc_carry = 4'd0;
		end
	endfunction

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
	endfunction

	// byte driver
	always @(negedge clk) begin : byte_driver
		raw_byte_t item;
		if (arst_n && (!byte_valid || byte_taken)) begin
			if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item = byte_queue.pop_front();
				data_byte  <= item.data;
				last_byte  <= item.fin;
				byte_valid <= 1'b1;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// character receiver
	always @(negedge clk) begin
		char_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: predict on byte transfers, check character transfers
	always @(posedge clk) begin : monitor
		enc_char_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("base64_stream_encoder: mismatch");
			$finish;
		end else if (arst_n) begin
			byte_taken = byte_valid && byte_ready;
			if (byte_taken) begin
				predict_chars(data_byte, last_byte);
				bytes_accepted++;
			end
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					note_error($sformatf("unexpected char 0x%02h last=%0b",
						out_char, last_char));
				end else begin
					want = expected_chars.pop_front();
					if (out_char !== want.code || last_char !== want.fin)
						note_error($sformatf("char exp 0x%02h last=%0b got 0x%02h last=%0b",
							want.code, want.fin, out_char, last_char));
				end
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_MODE) url_mode = value[0];
	endtask

	task automatic apb_check_mode();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_MODE;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'd0, url_mode})
			note_error($sformatf("mode read exp %0b got 0x%08h", url_mode, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		byte_queue.push_back('{data: b, fin: fin});
		bytes_queued++;
	endtask

	// random message, mostly short, sometimes long, with extreme bytes mixed in
	task automatic send_random_message(output int len);
		logic [7:0] b;
		len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(7))
				0:       b = 8'h00;
				1:       b = 8'hff;
				default: b = 8'($urandom_range(255));
			endcase
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic send_random_run(input int count);
		int len;
		int sent;
		sent = 0;
		while (sent < count) begin
			send_random_message(len);
			sent += len;
		end
	endtask

	// wait until every byte went in and every character came out
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || expected_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// stimulus sequence
	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		data_byte      = '0;
		last_byte      = 1'b0;
		byte_valid     = 1'b0;
		char_ready     = 1'b0;
		url_mode       = 1'b0;
		enc_phase      = PHASE_0;
		enc_carry      = 4'd0;
		byte_taken     = 1'b0;
		bytes_queued   = 0;
		bytes_accepted = 0;
		errors         = 0;
		cycles         = 0;
		send_idle_pct  = 34;
		recv_idle_pct  = 50;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, standard alphabet: each phase ends a message
		apb_check_mode();
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hfb, 1'b1);
		// message left open, mode flips before its last byte
		send_byte(8'hfb, 1'b0);
		send_byte(8'hef, 1'b0);
		wait_drained();
		apb_write(ADDR_MODE, {31'($urandom()), 1'b1});
		apb_check_mode();
		send_byte(8'hbe, 1'b1);
		wait_drained();

		// unmapped write must leave url-safe mode in place
		apb_write(ADDR_UNMAPPED, 32'd0);
		apb_check_mode();
		send_byte(8'hff, 1'b1);
		send_byte(8'hfb, 1'b0);
		send_byte(8'hf0, 1'b1);
		send_byte(8'hfc, 1'b0);
		send_byte(8'h0f, 1'b0);
		send_byte(8'hbf, 1'b1);
		wait_drained();

		// only bit 0 of the written value counts
		apb_write(ADDR_MODE, 32'hffff_fffe);
		apb_check_mode();
		send_byte(8'h3e, 1'b0);
		send_byte(8'hff, 1'b1);
		wait_drained();

		// random, standard alphabet, with one full pause in the middle
		send_random_run(30);
		wait_drained();
		send_random_run(30);
		wait_drained();

		// random, url-safe, idling swapped
		send_idle_pct = 50;
		recv_idle_pct = 34;
		apb_write(ADDR_MODE, 32'd1);
		send_random_run(60);
		wait_drained();

		// random, no idling, a few mode settings
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int k = 0; k < 3; k++) begin
			apb_write(ADDR_MODE, $urandom());
			apb_check_mode();
			send_random_run(22);
			wait_drained();
		end

		if (errors == 0 && expected_chars.size() == 0) begin
			$display("base64_stream_encoder: match");
		end else begin
			$display("base64_stream_encoder: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
tb/testbench.sv
